// ===== hdl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int INDEX_W = 10;   // entry_index / match_index width
    localparam int VALUE_W = 32;   // table entry and key width
    localparam int COUNT_W = 11;   // entry_count register width

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // search result handed to the output register
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [INDEX_W-1:0] match_index;
    } result_t;

endpackage

// ===== hdl/stbs_req_if.sv =====
// ----------------------------------------------------------------------------
// stbs_req_if
// Request channel: table writes and key searches.
// ----------------------------------------------------------------------------
interface stbs_req_if;
    import stbs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic        [INDEX_W-1:0] entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] search_key;

    modport source (
        output valid, opcode, entry_index, entry_value, search_key,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, entry_value, search_key,
        output ready
    );
endinterface

// ===== hdl/stbs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// stbs_rsp_if
// Response channel: one transaction per search.
// ----------------------------------------------------------------------------
interface stbs_rsp_if;
    import stbs_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] match_index;

    modport source (
        output valid, found, match_index,
        input  ready
    );

    modport sink (
        input  valid, found, match_index,
        output ready
    );
endinterface

// ===== hdl/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/stbs_search.sv =====
// ----------------------------------------------------------------------------
// stbs_search
// Search sequencer: takes request transactions, writes the table RAM, and
// walks the halving steps one RAM read per cycle.
// ----------------------------------------------------------------------------
module stbs_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    stbs_req_if.sink                              req,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      count,
    output logic                                  ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]        ram_waddr,
    output logic [stbs_pkg::VALUE_W-1:0]          ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]        ram_raddr,
    input  logic [stbs_pkg::VALUE_W-1:0]          ram_rdata,
    output stbs_pkg::result_t                     result,
    input  logic                                  result_ready
);
    import stbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    // range is [lo, hiex): hiex is one past the last candidate
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hiex_reg, hiex_next;
    logic [ADDR_W-1:0]         mid_reg, mid_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic                      found_reg, found_next;
    logic [INDEX_W-1:0]        idx_reg, idx_next;

    logic                      accept;
    logic                      is_search;
    logic                      in_range;
    logic [ADDR_W-1:0]         start_mid;
    logic [CNT_W-1:0]          count_m1;
    logic signed [VALUE_W-1:0] entry;
    logic                      hit;
    logic                      less;
    logic [CNT_W-1:0]          mid_ext;
    logic [CNT_W-1:0]          mid_p1;
    logic [CNT_W:0]            up_sum;
    logic [CNT_W:0]            dn_sum;
    logic [ADDR_W-1:0]         up_mid;
    logic [ADDR_W-1:0]         dn_mid;
    logic                      up_empty;
    logic                      dn_empty;

    assign accept    = req.valid && req.ready;
    assign is_search = (req.opcode == OP_SEARCH);
    assign in_range  = (32'(req.entry_index) < 32'(TABLE_DEPTH));
    assign count_m1  = count - CNT_W'(1);
    assign start_mid = ADDR_W'(count_m1 >> 1);

    // compare and both candidate next midpoints in parallel
    assign entry    = signed'(ram_rdata);
    assign hit      = (entry == key_reg);
    assign less     = (entry < key_reg);
    assign mid_ext  = CNT_W'(mid_reg);
    assign mid_p1   = mid_ext + CNT_W'(1);
    assign up_sum   = {1'b0, mid_ext} + {1'b0, hiex_reg};
    assign dn_sum   = {1'b0, lo_reg} + {1'b0, mid_ext} - (CNT_W + 1)'(1);
    assign up_mid   = ADDR_W'(up_sum[CNT_W:1]);
    assign dn_mid   = ADDR_W'(dn_sum[CNT_W:1]);
    assign up_empty = (mid_p1 >= hiex_reg);
    assign dn_empty = (lo_reg == mid_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hiex_reg  <= hiex_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        idx_reg   <= idx_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_search)
                begin
                    state_next = (count == '0) ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (hit || (less && up_empty) || (!less && dn_empty))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        lo_next    = lo_reg;
        hiex_next  = hiex_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                lo_next    = '0;
                hiex_next  = count;
                mid_next   = start_mid;
                key_next   = req.search_key;
                found_next = 1'b0;
                idx_next   = '0;
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    idx_next   = INDEX_W'(mid_reg);
                end
                else if (less)
                begin
                    lo_next  = mid_p1;
                    mid_next = up_mid;
                end
                else
                begin
                    hiex_next = mid_ext;
                    mid_next  = dn_mid;
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready          = 1'b0;
        ram_we             = 1'b0;
        ram_waddr          = ADDR_W'(req.entry_index);
        ram_wdata          = req.entry_value;
        ram_raddr          = mid_next;
        result.valid       = 1'b0;
        result.found       = found_reg;
        result.match_index = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                ram_we    = accept && !is_search && in_range;
            end
            ST_SEARCH:
            begin
            end
            ST_DONE:
            begin
                result.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a software-filled table of signed 32-bit entries.
// ----------------------------------------------------------------------------
// Search: a search over n entries makes at most floor(log2 n) + 1 table
//   reads, one per cycle, and its result then moves into the output register.
// Throughput: one transaction at a time; the next request is taken once the
//   result has moved into the output register. The per-step RAM read sets it.
// Reset: entry_count clears to 0, the table is not cleared (undefined until
//   written), the output register empties.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0] cfg_wdata,
    stbs_req_if.sink                     req,
    stbs_rsp_if.source                   rsp
);
    import stbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // entry_count, saturated to the table depth when written
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CMP_W-1:0] wr_ext;
    logic [CMP_W-1:0] depth_ext;

    // output register decouples the search engine from the consumer
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;

    result_t           result;
    logic              result_ready;
    logic              load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    assign wr_ext    = CMP_W'(cfg_wdata);
    assign depth_ext = CMP_W'(TABLE_DEPTH);

    always_comb
    begin
        count_next = count_reg;
        if (cfg_we)
        begin
            count_next = (wr_ext > depth_ext) ? CNT_W'(depth_ext) : CNT_W'(wr_ext);
        end
    end

    // result can move in when the register is empty or draining this cycle
    assign result_ready = !out_valid_reg || rsp.ready;
    assign load         = result.valid && result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_found_next = result.found;
            out_index_next = result.match_index;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.match_index = out_index_reg;

    stbs_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .count        (count_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .result       (result),
        .result_ready (result_ready)
    );

    // table storage, one read per search step
    stbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

// ===== dv/tb_sorted_table_binary_search.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search
// Self-checking bench: loads sorted (and some scrambled) tables of up to
// full depth, sets the entry count, and searches for hits, near misses and
// random keys. A predictor fed from the accepted request transactions holds
// the expected search results, and each response is compared against them.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
    localparam int SETTLE_CYCLES  = 20;    // covers a full-depth search
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction
    localparam int RANDOM_ITEMS   = 2000;

    typedef enum {FILL_SPREAD, FILL_DENSE, FILL_SCRAMBLED} fill_style_t;

    // one request transaction, plus a flag that makes the driver wait for
    // every outstanding search result before presenting it
    typedef struct {
        opcode_t                   op;
        logic        [INDEX_W-1:0] idx;
        logic signed [VALUE_W-1:0] val;
        logic signed [VALUE_W-1:0] key;
        bit                        hold;
    } table_txn_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] pos;
    } search_hit_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    stbs_req_if req_ch ();
    stbs_rsp_if rsp_ch ();

    sorted_table_binary_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // stimulus side
    table_txn_t                pending_txns[$];
    logic signed [VALUE_W-1:0] loaded_vals[TABLE_DEPTH];  // what the stimulus wrote
    int                        reqs_queued = 0;
    int                        send_idle_pct = 19;
    int                        recv_stall_pct = 82;

    // predictor side
    logic signed [VALUE_W-1:0] entry_mem[TABLE_DEPTH];
    logic        [COUNT_W-1:0] count_reg;
    search_hit_t               expected_hits[$];
    int                        hits_due;     // updated at the edge, read next cycle
    int                        reqs_taken;
    int                        fail_count = 0;

    // ------------------------------------------------------------------------
    // Clock and reset. All block inputs get known values at time zero.
    // ------------------------------------------------------------------------
    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_WRITE;
        req_ch.entry_index = '0;
        req_ch.entry_value = '0;
        req_ch.search_key  = '0;
        rsp_ch.ready       = 1'b0;
        fork
            forever #4 clk = ~clk;
        join_none
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Binary search over the shadow table, same halving as the block:
    // mid = floor((lo + hi) / 2), count saturated at the table depth.
    // ------------------------------------------------------------------------
    function automatic search_hit_t search_entries(input logic signed [VALUE_W-1:0] key);
        int          lo;
        int          hi;
        int          mid;
        search_hit_t r;
        r  = '0;
        lo = 0;
        hi = ((int'(count_reg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg)) - 1;
        while (lo <= hi && !r.found)
        begin
            mid = (lo + hi) / 2;
            if (entry_mem[mid] == key)
            begin
                r.found = 1'b1;
                r.pos   = INDEX_W'(mid);
            end
            else if (entry_mem[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: keeps valid up until the transaction is taken, idles
    // at random, and holds back a flagged transaction until the response
    // side has drained.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        table_txn_t t;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                (!pending_txns[0].hold || (hits_due == 0 && !req_ch.valid)))
            begin
                t = pending_txns.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.opcode      <= t.op;
                req_ch.entry_index <= t.idx;
                req_ch.entry_value <= t.val;
                req_ch.search_key  <= t.key;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: tracks the count register and table writes, predicts each
    // search at acceptance, and checks responses in order.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        search_hit_t want;
        int          pushed;
        int          popped;
        if (!rst_n)
        begin
            count_reg  = '0;
            hits_due   <= 0;
            reqs_taken <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            if (cfg_we)
                count_reg = cfg_wdata;
            if (req_ch.valid && req_ch.ready)
            begin
                reqs_taken <= reqs_taken + 1;
                if (req_ch.opcode == OP_WRITE)
                    entry_mem[req_ch.entry_index] = req_ch.entry_value;
                else
                begin
                    expected_hits.push_back(search_entries(req_ch.search_key));
                    pushed = 1;
                end
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected response, actual found=%0b match_index=%0d",
                             $time, rsp_ch.found, rsp_ch.match_index);
                    fail_count++;
                end
                else
                begin
                    want   = expected_hits.pop_front();
                    popped = 1;
                    if (rsp_ch.found !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want.found, rsp_ch.found);
                        fail_count++;
                    end
                    if (rsp_ch.match_index !== want.pos)
                    begin
                        $display("%0t: match_index mismatch, expected %0d, actual %0d",
                                 $time, want.pos, rsp_ch.match_index);
                        fail_count++;
                    end
                end
            end
            hits_due <= hits_due + pushed - popped;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a stretch with no transaction on either channel ends the run.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sorted_table_binary_search test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_write(input int idx, input logic signed [VALUE_W-1:0] v);
        table_txn_t t;
        t.op   = OP_WRITE;
        t.idx  = INDEX_W'(idx);
        t.val  = v;
        t.key  = $urandom;
        t.hold = 1'b0;
        pending_txns.push_back(t);
        loaded_vals[idx] = v;
        reqs_queued++;
    endtask

    task automatic push_search(input logic signed [VALUE_W-1:0] key, input bit hold);
        table_txn_t t;
        t.op   = OP_SEARCH;
        t.idx  = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        t.val  = $urandom;
        t.key  = key;
        t.hold = hold;
        pending_txns.push_back(t);
        reqs_queued++;
    endtask

    // everything queued has been taken and every result has come back
    task automatic wait_quiet();
        @(posedge clk);
        while (reqs_taken != reqs_queued || hits_due != 0)
            @(posedge clk);
    endtask

    // entry_count may only change while the block is idle
    task automatic program_count(input int c);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(c);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // write entries 0 .. n-1; spread and dense tables are ascending,
    // dense ones carry many duplicates, scrambled ones are unsorted
    task automatic fill_entries(input int n, input fill_style_t style);
        longint cur;
        longint span;
        longint step;
        span = 64'h1_0000_0000 / (n + 1);
        if (style == FILL_SPREAD)
            cur = -64'sd2147483648 + longint'($urandom) % span;
        else
            cur = longint'($signed($urandom));
        for (int i = 0; i < n; i++)
        begin
            if (style == FILL_SCRAMBLED)
                push_write(i, $urandom);
            else
            begin
                push_write(i, cur[VALUE_W-1:0]);
                if (style == FILL_SPREAD)
                    step = longint'($urandom) % (2 * span + 1);
                else
                    step = $urandom_range(0, 3);
                cur += step;
                if (cur > 64'sd2147483647)
                    cur = 64'sd2147483647;  // saturate, leaves a run of max values
            end
        end
    endtask

    // mostly keys that are present, then near misses, extremes and noise
    function automatic logic signed [VALUE_W-1:0] pick_key(input int c);
        int eff;
        int j;
        int r;
        eff = (c > TABLE_DEPTH) ? TABLE_DEPTH : c;
        r   = $urandom_range(0, 9);
        if (eff == 0 || r >= 8)
            return $urandom;
        j = $urandom_range(0, eff - 1);
        if (r < 5)
            return loaded_vals[j];
        if (r == 5)
            return loaded_vals[j] + 1;
        if (r == 6)
            return loaded_vals[j] - 1;
        return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          n;
        int          count;
        int          eff;
        int          m;
        int          r;
        bit          full_done;
        fill_style_t style;

        cfg_we    = 1'b0;
        cfg_wdata = '0;
        full_done = 1'b0;
        wait (rst_n);
        @(posedge clk);

        // -- directed: empty table after reset, every search misses
        push_search(32'sh8000_0000, 1'b0);
        push_search(32'sh7fff_ffff, 1'b0);
        push_search(32'sh0000_0000, 1'b0);

        // -- directed: four entries, spanning the value extremes
        push_write(0, 32'sh8000_0000);
        push_write(1, -32'sd5);
        push_write(2, 32'sd7);
        push_write(3, 32'sh7fff_ffff);
        push_write(TABLE_DEPTH - 1, -32'sd1);  // top slot, not searched yet
        program_count(4);
        push_search(32'sh8000_0000, 1'b0);
        push_search(-32'sd5, 1'b0);
        push_search(32'sd7, 1'b0);
        push_search(32'sh7fff_ffff, 1'b0);
        push_search(32'sd0, 1'b0);             // missing key between entries
        push_search(32'sd8, 1'b0);

        // -- directed: single entry
        program_count(1);
        push_search(32'sh8000_0000, 1'b0);
        push_search(32'sd7, 1'b1);             // held until the block drains

        // -- random phases: sender idles lightly, receiver stalls hard, then
        //    the other way round, then no idling at all
        while (reqs_queued < RANDOM_ITEMS)
        begin
            if (reqs_queued >= 1400)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (reqs_queued >= 700)
            begin
                send_idle_pct  = 82;
                recv_stall_pct = 19;
            end

            if (!full_done && reqs_queued >= 700)
            begin
                // whole table: full depth and a count above depth
                fill_entries(TABLE_DEPTH, FILL_SPREAD);
                program_count(TABLE_DEPTH);
                repeat (40) push_search(pick_key(TABLE_DEPTH), 1'b0);
                program_count(COUNT_MAX);
                repeat (30) push_search(pick_key(COUNT_MAX), 1'b0);
                full_done = 1'b1;
            end
            else
            begin
                // small tables dominate, a few mid-sized ones
                r = $urandom_range(0, 9);
                if (r < 7)
                    n = $urandom_range(1, 16);
                else if (r < 9)
                    n = $urandom_range(17, 100);
                else
                    n = $urandom_range(101, 300);

                r = $urandom_range(0, 9);
                if (r == 0)
                    style = FILL_SCRAMBLED;
                else if (r < 4)
                    style = FILL_DENSE;
                else
                    style = FILL_SPREAD;
                fill_entries(n, style);

                // count never reaches unwritten slots; once the whole table
                // has been written, counts above depth are fair game
                r = $urandom_range(0, 19);
                if (full_done && r == 0)
                    count = $urandom_range(TABLE_DEPTH + 1, COUNT_MAX);
                else if (r < 2)
                    count = 0;
                else if (r < 4)
                    count = $urandom_range(0, n);
                else
                    count = n;
                program_count(count);

                eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
                m   = $urandom_range(4, 30);
                repeat (m)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // stray write, kept outside the searched range when possible
                        if (eff < TABLE_DEPTH)
                            push_write($urandom_range(eff, TABLE_DEPTH - 1), $urandom);
                        else
                            push_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
                    end
                    else
                        push_search(pick_key(count), $urandom_range(0, 29) == 0);
                end
            end
        end

        // drain, then give the block time to emit anything unexpected
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_hits.size() != 0)
        begin
            $display("%0t: %0d search results never arrived", $time, expected_hits.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("sorted_table_binary_search test passed");
        else
            $display("sorted_table_binary_search test failed");
        $finish;
    end

endmodule
